// File: design/vt4_pkg.sv
// vt4_pkg: shared types and constants for the 4x4 vertex transform.
// Request payload structs, register map, reset values and datapath widths.
// No dependencies.
`default_nettype none

package vt4_pkg;

    localparam int COORD_W   = 32;
    localparam int FRAC_W    = 16;
    localparam int NUM_ROWS  = 4;
    localparam int NUM_COEF  = 3;
    localparam int NUM_REGS  = 2 * NUM_ROWS;
    localparam int REG_W     = 64;
    localparam int CFG_IDX_W = 8;
    localparam int REG_SEL_W = $clog2(NUM_REGS);

    // product Q32.32, pair sum, full row sum, row sum after dropping fraction
    localparam int PROD_W = 2 * COORD_W;
    localparam int PSUM_W = PROD_W + 1;
    localparam int SUM_W  = PROD_W + 2;
    localparam int RES_W  = SUM_W - FRAC_W;

    // register placement within a row pair
    localparam int REG_LEFT  = 0;
    localparam int REG_RIGHT = 1;

    localparam logic signed [PSUM_W-1:0] ROUND_HALF = PSUM_W'(1) <<< (FRAC_W - 1);
    localparam logic signed [COORD_W-1:0] SAT_MAX = {1'b0, {(COORD_W-1){1'b1}}};
    localparam logic signed [COORD_W-1:0] SAT_MIN = {1'b1, {(COORD_W-1){1'b0}}};

    // identity matrix
    localparam logic [REG_W-1:0] REG_RESET [NUM_REGS] = '{
        64'h0000_0000_0001_0000,
        64'h0000_0000_0000_0000,
        64'h0001_0000_0000_0000,
        64'h0000_0000_0000_0000,
        64'h0000_0000_0000_0000,
        64'h0000_0000_0001_0000,
        64'h0000_0000_0000_0000,
        64'h0001_0000_0000_0000
    };

    typedef struct packed {
        logic signed [COORD_W-1:0] px;
        logic signed [COORD_W-1:0] py;
        logic signed [COORD_W-1:0] pz;
    } point_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] tx;
        logic signed [COORD_W-1:0] ty;
        logic signed [COORD_W-1:0] tz;
        logic signed [COORD_W-1:0] tw;
        logic                      clipped;
    } result_t;

endpackage

`default_nettype wire

// File: design/vertex_transform_4x4.sv
// vertex_transform_4x4: Q16.16 point times row-major 4x4 matrix, w input fixed at 1.
// Throughput one point per cycle while the output is not stalled by m_ready.
// Stages: input reg, 12 multipliers, pair sums, row sums, round/saturate output reg.
// Synchronous active-low reset clears valids and loads the identity matrix.
// Depends on vt4_pkg.
`default_nettype none

module vertex_transform_4x4 (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,

    input  wire logic                             s_valid,
    output      logic                             s_ready,
    input  wire vt4_pkg::point_t                  s_data,

    output      logic                             m_valid,
    input  wire logic                             m_ready,
    output      vt4_pkg::result_t                 m_data,

    input  wire logic                             cfg_valid,
    output      logic                             cfg_ready,
    input  wire logic [vt4_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [vt4_pkg::REG_W-1:0]        cfg_data
);

    localparam int CW = vt4_pkg::COORD_W;

    logic [vt4_pkg::REG_W-1:0] cfg_reg [vt4_pkg::NUM_REGS];

    logic signed [CW-1:0] coef [vt4_pkg::NUM_ROWS][vt4_pkg::NUM_COEF];
    logic signed [CW-1:0] trans [vt4_pkg::NUM_ROWS];

    // stage valids
    logic v0_reg, v1_reg, v2_reg, v3_reg, out_v_reg;
    logic en0, en1, en2, en3, en_out;

    vt4_pkg::point_t pt_reg;
    logic signed [vt4_pkg::PROD_W-1:0] prod_reg [vt4_pkg::NUM_ROWS][vt4_pkg::NUM_COEF];
    logic signed [vt4_pkg::PSUM_W-1:0] sum_a_reg [vt4_pkg::NUM_ROWS];
    logic signed [vt4_pkg::PSUM_W-1:0] sum_b_reg [vt4_pkg::NUM_ROWS];
    logic signed [vt4_pkg::SUM_W-1:0]  total_reg [vt4_pkg::NUM_ROWS];
    vt4_pkg::result_t                  out_reg;

    logic signed [CW-1:0] row_res [vt4_pkg::NUM_ROWS];
    logic [vt4_pkg::NUM_ROWS-1:0] row_sat;
    vt4_pkg::result_t out_next;

    // configuration
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < vt4_pkg::NUM_REGS; i++) begin
                cfg_reg[i] <= vt4_pkg::REG_RESET[i];
            end
        end else if (cfg_valid && cfg_ready &&
                     (cfg_index < vt4_pkg::CFG_IDX_W'(vt4_pkg::NUM_REGS))) begin
            cfg_reg[cfg_index[vt4_pkg::REG_SEL_W-1:0]] <= cfg_data;
        end
    end

    always_comb begin
        for (int r = 0; r < vt4_pkg::NUM_ROWS; r++) begin
            coef[r][0] = cfg_reg[2*r + vt4_pkg::REG_LEFT][CW-1:0];
            coef[r][1] = cfg_reg[2*r + vt4_pkg::REG_LEFT][2*CW-1:CW];
            coef[r][2] = cfg_reg[2*r + vt4_pkg::REG_RIGHT][CW-1:0];
            trans[r]   = cfg_reg[2*r + vt4_pkg::REG_RIGHT][2*CW-1:CW];
        end
    end

    // pipeline flow control
    assign en_out  = !out_v_reg || m_ready;
    assign en3     = !v3_reg || en_out;
    assign en2     = !v2_reg || en3;
    assign en1     = !v1_reg || en2;
    assign en0     = !v0_reg || en1;
    assign s_ready = en0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v0_reg    <= 1'b0;
            v1_reg    <= 1'b0;
            v2_reg    <= 1'b0;
            v3_reg    <= 1'b0;
            out_v_reg <= 1'b0;
        end else begin
            if (en0)    v0_reg    <= s_valid;
            if (en1)    v1_reg    <= v0_reg;
            if (en2)    v2_reg    <= v1_reg;
            if (en3)    v3_reg    <= v2_reg;
            if (en_out) out_v_reg <= v3_reg;
        end
    end

    // stage 0: input capture
    always_ff @(posedge aclk) begin
        if (en0 && s_valid) begin
            pt_reg <= s_data;
        end
    end

    // stage 1: products, Q32.32
    always_ff @(posedge aclk) begin
        if (en1 && v0_reg) begin
            for (int r = 0; r < vt4_pkg::NUM_ROWS; r++) begin
                prod_reg[r][0] <= vt4_pkg::PROD_W'(pt_reg.px) * vt4_pkg::PROD_W'(coef[r][0]);
                prod_reg[r][1] <= vt4_pkg::PROD_W'(pt_reg.py) * vt4_pkg::PROD_W'(coef[r][1]);
                prod_reg[r][2] <= vt4_pkg::PROD_W'(pt_reg.pz) * vt4_pkg::PROD_W'(coef[r][2]);
            end
        end
    end

    // stage 2: pair sums; translation scaled to Q32.32 plus half LSB
    always_ff @(posedge aclk) begin
        if (en2 && v1_reg) begin
            for (int r = 0; r < vt4_pkg::NUM_ROWS; r++) begin
                sum_a_reg[r] <= vt4_pkg::PSUM_W'(prod_reg[r][0])
                              + vt4_pkg::PSUM_W'(prod_reg[r][1]);
                sum_b_reg[r] <= vt4_pkg::PSUM_W'(prod_reg[r][2])
                              + (vt4_pkg::PSUM_W'(trans[r]) <<< vt4_pkg::FRAC_W)
                              + vt4_pkg::ROUND_HALF;
            end
        end
    end

    // stage 3: row sums
    always_ff @(posedge aclk) begin
        if (en3 && v2_reg) begin
            for (int r = 0; r < vt4_pkg::NUM_ROWS; r++) begin
                total_reg[r] <= vt4_pkg::SUM_W'(sum_a_reg[r]) + vt4_pkg::SUM_W'(sum_b_reg[r]);
            end
        end
    end

    // stage 4: floor to Q16.16, saturate
    always_comb begin
        logic signed [vt4_pkg::RES_W-1:0] shifted;
        logic                             hi_over;
        logic                             lo_over;
        for (int r = 0; r < vt4_pkg::NUM_ROWS; r++) begin
            shifted = total_reg[r][vt4_pkg::SUM_W-1:vt4_pkg::FRAC_W];
            hi_over = !shifted[vt4_pkg::RES_W-1] && (|shifted[vt4_pkg::RES_W-2:CW-1]);
            lo_over = shifted[vt4_pkg::RES_W-1] && !(&shifted[vt4_pkg::RES_W-2:CW-1]);
            row_sat[r] = hi_over || lo_over;
            if (hi_over) begin
                row_res[r] = vt4_pkg::SAT_MAX;
            end else if (lo_over) begin
                row_res[r] = vt4_pkg::SAT_MIN;
            end else begin
                row_res[r] = shifted[CW-1:0];
            end
        end
        out_next.tx      = row_res[0];
        out_next.ty      = row_res[1];
        out_next.tz      = row_res[2];
        out_next.tw      = row_res[3];
        out_next.clipped = |row_sat;
    end

    always_ff @(posedge aclk) begin
        if (en_out && v3_reg) begin
            out_reg <= out_next;
        end
    end

    assign m_valid = out_v_reg;
    assign m_data  = out_reg;

endmodule

`default_nettype wire
